@@ design/cosine_similarity_engine_unit_macros.svh @@
// Assertion macros shared by the cosine similarity engine.
`ifndef COSINE_SIMILARITY_ENGINE_UNIT_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cse_pkg.sv @@
// Types and constants shared by the cosine similarity engine modules.
`default_nettype none

package cse_pkg;

    localparam int ELEM_W     = 16;
    localparam int SIM_W      = 16;
    localparam int N_W        = 34;
    localparam int ROOT_W     = 17;
    localparam int REM_W      = 20;
    localparam int DIV_STEPS  = 33;
    localparam int SQRT_STEPS = 17;
    localparam int STEP_CNT_W = 6;

    localparam logic [SIM_W-1:0] SIM_MAX = 16'h7FFF;

    typedef enum logic [2:0] {
        S_ACCUM,
        S_CHECK,
        S_MUL_P,
        S_MUL_D,
        S_DIV,
        S_SQRT,
        S_DONE
    } cse_state_t;

    typedef struct packed {
        logic acc_en;
        logic mul_start;
        logic mul_sel_d;
        logic load_p;
        logic load_d;
        logic div_step;
        logic sqrt_step;
        logic result_load;
    } cse_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic zero_norm;
    } cse_stat_t;

endpackage

`default_nettype wire

@@ design/cosine_similarity_engine_unit.sv @@
// Top level of the streaming cosine similarity engine.
// Element pairs are taken at one per cycle while accumulating.
// After the final pair, unless a norm is zero, the result is computed by two bit-serial products of
// DOT_W = clog2(MAX_LEN+1)+32 bits, a 33-step divide and a 17-step square root.
// The input is held off during that computation; a pending result does not block the next vector's pairs.
// Synchronous active-low reset clears the accumulators, counters and output valid.
`default_nettype none
`include "cosine_similarity_engine_unit_macros.svh"

module cosine_similarity_engine_unit #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // elem_a [15:0], elem_b [31:16]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // similarity [15:0]
    output logic [1:0]       m_tuser    // zero_norm [0], length_overflow [1]
);

    import cse_pkg::*;

    cse_cmd_t         cmd;
    cse_stat_t        stat;
    logic [SIM_W-1:0] similarity;
    logic             zero_norm;
    logic             length_overflow;

    cse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    cse_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .elem_a          (s_tdata[ELEM_W-1:0]),
        .elem_b          (s_tdata[2*ELEM_W-1:ELEM_W]),
        .cmd             (cmd),
        .stat            (stat),
        .similarity      (similarity),
        .zero_norm       (zero_norm),
        .length_overflow (length_overflow)
    );

    assign m_tdata = similarity;
    assign m_tuser = {length_overflow, zero_norm};

    `CSE_ASSERT_NEXT(a_hold_after_last, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready, "input request accepted during the result computation")
    `CSE_ASSERT_SAME(a_zero_norm_result, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 16'h0000, "zero norm result carries a nonzero similarity")
    `CSE_ASSERT_SAME(a_ready_with_result, aclk, aresetn, $rose(m_tvalid), s_tready, "input not reopened when a result was loaded")

endmodule

`default_nettype wire

@@ design/cse_seqmul.sv @@
// Unsigned shift-and-add multiplier that retires one multiplier bit per cycle.
`default_nettype none

module cse_seqmul #(
    parameter int W = 43
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [W-1:0]   x,
    input  wire logic [W-1:0]   y,
    output logic                done,
    output logic [2*W-1:0]      product
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  mcand_reg, mcand_next;
    logic [W-1:0]  hi_reg, hi_next;
    logic [W-1:0]  lo_reg, lo_next;
    logic [W:0]    sum;

    always_comb begin
        sum        = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : {(W + 1){1'b0}});
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            mcand_next = x;
            hi_next    = '0;
            lo_next    = y;
        end else if (busy_reg) begin
            hi_next  = sum[W:1];
            lo_next  = {sum[0], lo_reg[W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

@@ design/cse_ctrl.sv @@
// Controller state machine that sequences accumulation, the final arithmetic and the output.
`default_nettype none

module cse_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tlast,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output cse_pkg::cse_cmd_t  cmd,
    input  wire cse_pkg::cse_stat_t stat
);

    import cse_pkg::*;

    cse_state_t            state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_ACCUM;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            S_ACCUM: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.acc_en = 1'b1;
                    if (s_tlast) begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (stat.zero_norm) begin
                    state_next = S_DONE;
                end else begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL_P;
                end
            end
            S_MUL_P: begin
                if (stat.mul_done) begin
                    cmd.load_p    = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel_d = 1'b1;
                    state_next    = S_MUL_D;
                end
            end
            S_MUL_D: begin
                if (stat.mul_done) begin
                    cmd.load_d = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == STEP_CNT_W'(SQRT_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.result_load = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = S_ACCUM;
                end
            end
            default: begin
                state_next = S_ACCUM;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

@@ design/cse_datapath.sv @@
// Datapath with the accumulators, the product, divide and square root steps and the result register.
`default_nettype none

module cse_datapath #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic signed [cse_pkg::ELEM_W-1:0] elem_a,
    input  wire logic signed [cse_pkg::ELEM_W-1:0] elem_b,
    input  wire cse_pkg::cse_cmd_t             cmd,
    output cse_pkg::cse_stat_t                 stat,
    output logic [cse_pkg::SIM_W-1:0]          similarity,
    output logic                               zero_norm,
    output logic                               length_overflow
);

    import cse_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int SQ_W  = CNT_W + 31;
    localparam int DOT_W = CNT_W + 32;
    localparam int MW    = DOT_W;
    localparam int P_W   = 2 * SQ_W;
    localparam int R_W   = P_W + 1;
    localparam int PR_W  = 2 * ELEM_W;

    logic [SQ_W-1:0]   sq_a_reg, sq_a_next;
    logic [SQ_W-1:0]   sq_b_reg, sq_b_next;
    logic [DOT_W-1:0]  dot_reg, dot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ovf_reg, ovf_next;
    logic [P_W-1:0]    p_reg, p_next;
    logic [R_W-1:0]    r_reg, r_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SIM_W-1:0]  sim_reg, sim_next;
    logic              zn_reg, zn_next;
    logic              ovfo_reg, ovfo_next;

    logic signed [PR_W-1:0] prod_aa, prod_bb, prod_ab;
    logic                   room;
    logic                   norm_zero;
    logic                   dot_neg;
    logic [DOT_W-1:0]       mag;
    logic [MW-1:0]          mul_x, mul_y;
    logic                   mul_done;
    logic [2*MW-1:0]        mul_product;
    logic                   div_ge;
    logic [R_W-1:0]         r_sub;
    logic [REM_W-1:0]       rem_sh, trial;
    logic                   sqrt_ge;
    logic [ROOT_W:0]        q_sum;
    logic [ROOT_W-1:0]      q_mag, q_neg;
    logic [SIM_W-1:0]       sim_calc;

    assign prod_aa = elem_a * elem_a;
    assign prod_bb = elem_b * elem_b;
    assign prod_ab = elem_a * elem_b;

    assign room      = cnt_reg < CNT_W'(MAX_LEN);
    assign norm_zero = (sq_a_reg == '0) || (sq_b_reg == '0);
    assign dot_neg   = dot_reg[DOT_W-1];
    assign mag       = dot_neg ? ({DOT_W{1'b0}} - dot_reg) : dot_reg;

    assign mul_x = cmd.mul_sel_d ? mag : {{(MW - SQ_W){1'b0}}, sq_a_reg};
    assign mul_y = cmd.mul_sel_d ? mag : {{(MW - SQ_W){1'b0}}, sq_b_reg};

    cse_seqmul #(
        .W (MW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .done    (mul_done),
        .product (mul_product)
    );

    always_comb begin
        div_ge  = r_reg >= {1'b0, p_reg};
        r_sub   = div_ge ? (r_reg - {1'b0, p_reg}) : r_reg;
        rem_sh  = {rem_reg[REM_W-3:0], n_reg[N_W-1:N_W-2]};
        trial   = {{(REM_W - ROOT_W - 2){1'b0}}, root_reg, 2'b01};
        sqrt_ge = rem_sh >= trial;
        q_sum   = {1'b0, root_reg} + {{ROOT_W{1'b0}}, 1'b1};
        q_mag   = q_sum[ROOT_W:1];
        q_neg   = {ROOT_W{1'b0}} - q_mag;
        if (norm_zero) begin
            sim_calc = '0;
        end else if (dot_neg) begin
            sim_calc = q_neg[SIM_W-1:0];
        end else if (q_mag > ROOT_W'(SIM_MAX)) begin
            sim_calc = SIM_MAX;
        end else begin
            sim_calc = q_mag[SIM_W-1:0];
        end
    end

    always_comb begin
        sq_a_next = sq_a_reg;
        sq_b_next = sq_b_reg;
        dot_next  = dot_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        p_next    = p_reg;
        r_next    = r_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        sim_next  = sim_reg;
        zn_next   = zn_reg;
        ovfo_next = ovfo_reg;
        if (cmd.acc_en) begin
            if (room) begin
                sq_a_next = sq_a_reg + {{(SQ_W - PR_W){1'b0}}, prod_aa};
                sq_b_next = sq_b_reg + {{(SQ_W - PR_W){1'b0}}, prod_bb};
                dot_next  = dot_reg + {{(DOT_W - PR_W){prod_ab[PR_W-1]}}, prod_ab};
                cnt_next  = cnt_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.load_p) begin
            p_next = mul_product[P_W-1:0];
        end
        if (cmd.load_d) begin
            r_next    = {1'b0, mul_product[P_W-1:0]};
            n_next    = '0;
            rem_next  = '0;
            root_next = '0;
        end
        if (cmd.div_step) begin
            r_next = {r_sub[R_W-2:0], 1'b0};
            n_next = {n_reg[N_W-2:0], div_ge};
        end
        if (cmd.sqrt_step) begin
            rem_next  = sqrt_ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[ROOT_W-2:0], sqrt_ge};
            n_next    = {n_reg[N_W-3:0], 2'b00};
        end
        if (cmd.result_load) begin
            sim_next  = sim_calc;
            zn_next   = norm_zero;
            ovfo_next = ovf_reg;
            sq_a_next = '0;
            sq_b_next = '0;
            dot_next  = '0;
            cnt_next  = '0;
            ovf_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_a_reg <= '0;
            sq_b_reg <= '0;
            dot_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            sq_a_reg <= sq_a_next;
            sq_b_reg <= sq_b_next;
            dot_reg  <= dot_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg    <= p_next;
        r_reg    <= r_next;
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        sim_reg  <= sim_next;
        zn_reg   <= zn_next;
        ovfo_reg <= ovfo_next;
    end

    assign stat = '{mul_done: mul_done, zero_norm: norm_zero};

    assign similarity      = sim_reg;
    assign zero_norm       = zn_reg;
    assign length_overflow = ovfo_reg;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the streaming cosine similarity engine.
`timescale 1ns / 1ps

module testbench;

    localparam int VEC_LIMIT    = 1024;
    localparam int RANDOM_ITEMS = 360;
    localparam int TAIL_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic [15:0] similarity;
        logic        zero_norm;
        logic        length_overflow;
    } cos_score_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    cos_score_t expected_scores[$];
    cos_score_t score_want;

    longint sum_sq_a;
    longint sum_sq_b;
    longint dot_acc;
    int     pairs_taken;
    logic   extra_seen;

    int   mismatches  = 0;
    int   cycle_count = 0;
    int   ready_hold  = 0;
    logic hold_drawn  = 1'b0;
    logic rx_burst    = 1'b0;
    logic tx_burst    = 1'b0;

    cosine_similarity_engine_unit #(
        .MAX_LEN(VEC_LIMIT)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [15:0] cosine_q15(longint sa, longint sb, longint dot);
        logic [159:0] norm_prod;
        logic [159:0] dot_sq_scaled;
        logic [63:0]  mag;
        logic [16:0]  q;
        logic [16:0]  c;
        logic [17:0]  t;
        mag = (dot < 0) ? -dot : dot;
        norm_prod = 160'(sa) * 160'(sb);
        dot_sq_scaled = (160'(mag) * 160'(mag)) << 32;
        q = '0;
        for (int i = 15; i >= 0; i--) begin
            c = q | (17'd1 << i);
            t = 18'(2 * c - 1);
            if (c <= 17'd32768 && norm_prod * 160'(t) * 160'(t) <= dot_sq_scaled) begin
                q = c;
            end
        end
        if (dot < 0) begin
            return 16'(17'd65536 - q);
        end
        return (q > 17'(cse_pkg::SIM_MAX)) ? cse_pkg::SIM_MAX : q[15:0];
    endfunction

    task automatic clear_accumulators();
        sum_sq_a    = 0;
        sum_sq_b    = 0;
        dot_acc     = 0;
        pairs_taken = 0;
        extra_seen  = 1'b0;
    endtask

    // Every accepted request advances the predicted accumulator state or, past the limit, marks the overflow.
    task automatic accumulate_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
        cos_score_t score;
        if (pairs_taken < VEC_LIMIT) begin
            sum_sq_a += a * a;
            sum_sq_b += b * b;
            dot_acc  += a * b;
            pairs_taken++;
        end else begin
            extra_seen = 1'b1;
        end
        if (last) begin
            if (sum_sq_a == 0 || sum_sq_b == 0) begin
                score.similarity = '0;
                score.zero_norm  = 1'b1;
            end else begin
                score.similarity = cosine_q15(sum_sq_a, sum_sq_b, dot_acc);
                score.zero_norm  = 1'b0;
            end
            score.length_overflow = extra_seen;
            expected_scores.push_back(score);
            clear_accumulators();
        end
    endtask

    task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        accumulate_pair(a, b, last);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch %0d at cycle %0d: %s got %0d expected %0d",
                 mismatches, cycle_count, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_scores.size() == 0) begin
                report_mismatch("unexpected result, similarity", int'($signed(m_tdata)), 0);
            end else begin
                score_want = expected_scores.pop_front();
                if (m_tdata !== score_want.similarity) begin
                    report_mismatch("similarity", int'($signed(m_tdata)),
                                    int'($signed(score_want.similarity)));
                end
                if (m_tuser[0] !== score_want.zero_norm) begin
                    report_mismatch("zero_norm", int'(m_tuser[0]), int'(score_want.zero_norm));
                end
                if (m_tuser[1] !== score_want.length_overflow) begin
                    report_mismatch("length_overflow", int'(m_tuser[1]),
                                    int'(score_want.length_overflow));
                end
            end
            hold_drawn = 1'b0;
            rx_burst   = ($urandom_range(0, 6) == 0);
        end else if (aresetn && m_tvalid && !hold_drawn) begin
            ready_hold = rx_burst ? 0 : $urandom_range(0, 10);
            hold_drawn = 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_drawn) begin
            m_tready <= (ready_hold == 0);
        end else begin
            m_tready <= rx_burst ? 1'b1 : 1'($urandom_range(0, 1));
        end
    end

    function automatic logic [15:0] pick_elem(int kind);
        logic [15:0] corner[6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001};
        case (kind)
            0: return 16'($urandom_range(0, 65535));
            1: return corner[$urandom_range(0, 5)];
            2: return 16'($urandom_range(0, 16) - 8);
            default: return 16'h0000;
        endcase
    endfunction

    function automatic int pick_kind();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 12) return 0;
        if (roll < 15) return 1;
        if (roll < 18) return 2;
        return 3;
    endfunction

    task automatic test_full_scale();
        tx_burst = 1'b0;
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(16'sh7FFF, 16'sh8000, 1'b1);
        send_pair(16'sh0001, 16'shFFFF, 1'b1);
    endtask

    task automatic test_zero_norm();
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        send_pair(16'sh0000, 16'sh8000, 1'b1);
        send_pair(16'sh7FFF, 16'sh0000, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b0);
        send_pair(16'sh0000, 16'sh0005, 1'b1);
    endtask

    task automatic test_direction();
        tx_burst = 1'b1;
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(16'sd3, 16'sd4, 1'b0);
        send_pair(16'sd4, 16'sd3, 1'b1);
        send_pair(16'sd100, -16'sd100, 1'b0);
        send_pair(-16'sd200, 16'sd200, 1'b1);
        tx_burst = 1'b0;
        wait_drained();
    endtask

    // The final pair lands one past the limit, so it must be ignored but still end the vector.
    task automatic test_length_limit();
        tx_burst = 1'b1;
        for (int i = 0; i < VEC_LIMIT; i++) begin
            send_pair(pick_elem(0), pick_elem(0), 1'b0);
        end
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        tx_burst = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_vectors();
        int sent;
        int len;
        int shape;
        int kind_a;
        int kind_b;
        logic signed [15:0] a;
        logic signed [15:0] b;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            len    = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 200) : $urandom_range(1, 12);
            shape  = $urandom_range(0, 5);
            kind_a = pick_kind();
            kind_b = pick_kind();
            tx_burst = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++) begin
                a = pick_elem(kind_a);
                case (shape)
                    1: b = a;
                    2: b = -a;
                    3: b = a >>> $urandom_range(1, 4);
                    4: b = a + 16'($urandom_range(0, 64) - 32);
                    5: b = pick_elem(pick_kind());
                    default: b = pick_elem(kind_b);
                endcase
                send_pair(a, b, i == len - 1);
            end
            sent += len;
            if ($urandom_range(0, 39) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        clear_accumulators();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_full_scale();
        test_zero_norm();
        test_direction();
        test_length_limit();
        test_random_vectors();
        s_tvalid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/cse_pkg.sv
design/cse_seqmul.sv
design/cse_ctrl.sv
design/cse_datapath.sv
design/cosine_similarity_engine_unit.sv
tb/testbench.sv
